/* rtl/core/fpas_pkg.sv */
package fpas_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7fc00000;
    localparam logic [7:0]  EXP_ONES  = 8'hff;
    localparam int unsigned MAX_GAP   = 24;

    // Special-case outcome decided in the first stage.
    typedef enum logic [1:0] {
        SPC_NONE = 2'd0,
        SPC_NAN  = 2'd1,
        SPC_PASS = 2'd2
    } spc_t;

    // Stage 1 to stage 2: aligned signed significands.
    typedef struct packed {
        spc_t        spc;
        logic [31:0] pass_bits;
        logic [7:0]  ex;
        logic        sa;
        logic        sb;
        logic [24:0] ma;
        logic [24:0] mb;
    } s1_t;

    // Stage 2 to stage 3: rounded sign and magnitude.
    typedef struct packed {
        spc_t        spc;
        logic [31:0] pass_bits;
        logic [7:0]  ex;
        logic        sign;
        logic [24:0] mag;
    } s2_t;

    // Stage 3 to stage 4: magnitude with leading-zero count.
    typedef struct packed {
        spc_t        spc;
        logic [31:0] pass_bits;
        logic [7:0]  ex;
        logic        sign;
        logic [24:0] mag;
        logic [4:0]  lz;
    } s3_t;

endpackage

/* rtl/core/fpas_align.sv */
module fpas_align (
    input  logic                kind,
    input  logic [31:0]         operand_a,
    input  logic [31:0]         operand_b,
    output fpas_pkg::s1_t       s1
);
    import fpas_pkg::*;

    logic [31:0] b;
    logic [7:0]  ea, eb, d;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [24:0] ma, mb;

    always_comb begin
        b     = {operand_b[31] ^ kind, operand_b[30:0]};
        ea    = operand_a[30:23];
        eb    = b[30:23];
        nan_a = (ea == EXP_ONES) && (operand_a[22:0] != 23'd0);
        nan_b = (eb == EXP_ONES) && (b[22:0] != 23'd0);
        inf_a = (ea == EXP_ONES) && (operand_a[22:0] == 23'd0);
        inf_b = (eb == EXP_ONES) && (b[22:0] == 23'd0);
        ma    = (operand_a[30:0] == 31'd0) ? 25'd0 : {1'b1, operand_a[22:0], 1'b0};
        mb    = (b[30:0] == 31'd0) ? 25'd0 : {1'b1, b[22:0], 1'b0};

        s1.pass_bits = operand_a;
        if (nan_a || nan_b) begin
            s1.spc = SPC_NAN;
        end else if (inf_a && inf_b) begin
            s1.spc = (operand_a[31] == b[31]) ? SPC_PASS : SPC_NAN;
        end else if (inf_a) begin
            s1.spc = SPC_PASS;
        end else if (inf_b) begin
            s1.spc       = SPC_PASS;
            s1.pass_bits = b;
        end else begin
            s1.spc = SPC_NONE;
        end

        if (ea >= eb) begin
            d     = ea - eb;
            s1.ex = ea;
            s1.ma = ma;
            s1.mb = (d > 8'(MAX_GAP)) ? 25'd0 : (mb >> d);
        end else begin
            d     = eb - ea;
            s1.ex = eb;
            s1.mb = mb;
            s1.ma = (d > 8'(MAX_GAP)) ? 25'd0 : (ma >> d);
        end
        s1.sa = operand_a[31];
        s1.sb = b[31];
    end

endmodule

/* rtl/core/fpas_addrnd.sv */
module fpas_addrnd (
    input  fpas_pkg::s1_t s1,
    output fpas_pkg::s2_t s2
);
    import fpas_pkg::*;

    logic signed [26:0] va, vb, s, h;
    logic [26:0]        neg_s;

    always_comb begin
        va    = s1.sa ? -$signed({2'b00, s1.ma}) : $signed({2'b00, s1.ma});
        vb    = s1.sb ? -$signed({2'b00, s1.mb}) : $signed({2'b00, s1.mb});
        s     = va + vb + 27'sd1;
        neg_s = 27'(-s + 27'sd1);
        // Round half up: arithmetic floor of s/2 for either sign.
        if (s >= 0) begin
            h = s >>> 1;
        end else begin
            h = -$signed({1'b0, neg_s[26:1]});
        end
        s2.spc       = s1.spc;
        s2.pass_bits = s1.pass_bits;
        s2.ex        = s1.ex;
        s2.sign      = h[26];
        s2.mag       = h[26] ? 25'(-h) : h[24:0];
    end

endmodule

/* rtl/core/fpas_norm.sv */
module fpas_norm (
    input  fpas_pkg::s3_t s3,
    output logic [31:0]   sum_bits
);
    import fpas_pkg::*;

    logic signed [9:0] ex;
    logic [24:0]       mag;

    always_comb begin
        ex  = $signed({2'b00, s3.ex});
        mag = s3.mag;
        if (mag == 25'd0) begin
            ex = 10'sd0;
        end else if (mag[24]) begin
            mag = 25'(mag[24:1]) + 25'(mag[0]);
            ex  = ex + 10'sd1;
            if (mag[24]) begin
                mag = mag >> 1;
                ex  = ex + 10'sd1;
            end
        end else begin
            mag = mag << s3.lz;
            ex  = ex - $signed({5'd0, s3.lz});
        end
        if (ex < 0) begin
            ex  = 10'sd0;
            mag = 25'd0;
        end
        case (s3.spc)
            SPC_NAN:  sum_bits = QNAN_BITS;
            SPC_PASS: sum_bits = s3.pass_bits;
            default: begin
                if (ex >= 10'sd255) begin
                    sum_bits = {s3.sign, EXP_ONES, 23'd0};
                end else begin
                    sum_bits = {s3.sign, ex[7:0], mag[22:0]};
                end
            end
        endcase
    end

endmodule

/* rtl/core/fp32_add_sub_top.sv */
// Four-stage pipeline: align, add and round, leading-zero count, normalize.
// m_valid is set once a transfer has passed the s1, s2, s3 and out registers;
// throughput is one transfer per cycle while m_ready is high or m_valid is low.
// A stall holds every stage; nothing is lost or repeated.
// aresetn (synchronous, active low) clears all stage valid bits.
module fp32_add_sub_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sum_bits
);
    import fpas_pkg::*;

    s1_t         s1_next, s1_reg;
    s2_t         s2_next, s2_reg;
    s3_t         s3_next, s3_reg;
    logic [31:0] out_next, out_reg;
    logic [3:0]  v_reg;
    logic        adv;

    assign adv     = m_ready || !v_reg[3];
    assign s_ready = adv;
    assign m_valid = v_reg[3];
    assign m_sum_bits = out_reg;

    fpas_align u_align (
        .kind      (s_kind),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .s1        (s1_next)
    );

    fpas_addrnd u_addrnd (
        .s1 (s1_reg),
        .s2 (s2_next)
    );

    always_comb begin
        s3_next.spc       = s2_reg.spc;
        s3_next.pass_bits = s2_reg.pass_bits;
        s3_next.ex        = s2_reg.ex;
        s3_next.sign      = s2_reg.sign;
        s3_next.mag       = s2_reg.mag;
        s3_next.lz        = 5'd0;
        for (int i = 0; i <= 23; i++) begin
            if (s2_reg.mag[i]) begin
                s3_next.lz = 5'(23 - i);
            end
        end
    end

    fpas_norm u_norm (
        .s3       (s3_reg),
        .sum_bits (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 4'd0;
        end else if (adv) begin
            v_reg <= {v_reg[2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end

endmodule

/* bench/fp32_add_sub_checker.sv */
module fp32_add_sub_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_sum_bits,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpas_pkg::*;

    localparam logic [31:0] SIGN_MASK = 32'h80000000;
    localparam logic [31:0] INF_BITS  = 32'h7f800000;

    logic [31:0] sums_q[$];

    function automatic logic is_nan(logic [31:0] v);
        return v[30:23] == EXP_ONES && v[22:0] != 0;
    endfunction

    function automatic logic is_inf(logic [31:0] v);
        return v[30:23] == EXP_ONES && v[22:0] == 0;
    endfunction

    function automatic longint signif(logic [31:0] v);
        if (v[30:0] == 0) return 0;
        return longint'({1'b1, v[22:0], 1'b0});
    endfunction

    function automatic logic [31:0] fp_sum(logic kind, logic [31:0] a, logic [31:0] b0);
        logic [31:0] b;
        longint ma, mb, s, h, mag;
        int ex, ea, eb, d;
        logic sign;
        b = kind ? (b0 ^ SIGN_MASK) : b0;
        if (is_nan(a) || is_nan(b)) return QNAN_BITS;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN_BITS;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        ea = a[30:23];
        eb = b[30:23];
        ma = signif(a);
        mb = signif(b);
        ex = ea;
        if (ea > eb) begin
            d = ea - eb;
            mb = (d > MAX_GAP) ? 0 : (mb >>> d);
        end else if (eb > ea) begin
            d = eb - ea;
            ex = eb;
            ma = (d > MAX_GAP) ? 0 : (ma >>> d);
        end
        if (a[31]) ma = -ma;
        if (b[31]) mb = -mb;
        // Drop the guard bit, rounding half toward plus infinity.
        s = ma + mb + 1;
        h = (s >= 0) ? (s >>> 1) : -((-s + 1) >>> 1);
        sign = h < 0;
        mag = sign ? -h : h;
        if (mag == 0) begin
            ex = 0;
        end else if (mag[24]) begin
            mag = (mag >> 1) + (mag & 1);
            ex++;
            if (mag[24]) begin
                mag = mag >> 1;
                ex++;
            end
        end else begin
            while (!mag[23]) begin
                mag = mag << 1;
                ex--;
            end
        end
        if (ex < 0) begin
            ex = 0;
            mag = 0;
        end
        if (ex >= 255) return {sign, INF_BITS[30:0]};
        return {sign, ex[7:0], mag[22:0]};
    endfunction

    assign pending = sums_q.size();

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_valid && s_ready)
                sums_q.push_back(fp_sum(s_kind, s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                if (sums_q.size() == 0) begin
                    $display("%0t: unexpected sum %h", $time, m_sum_bits);
                    errors <= errors + 1;
                end else begin
                    want = sums_q.pop_front();
                    if (want !== m_sum_bits) begin
                        $display("%0t: sum_bits expected %h actual %h",
                                 $time, want, m_sum_bits);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* bench/tb_fp32_add_sub_top.sv */
module tb_fp32_add_sub_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_kind = 0;
    logic [31:0] s_operand_a = 0;
    logic [31:0] s_operand_b = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_sum_bits;
    int          errors;
    int          pending;
    int          cycles = 0;
    logic        calm = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    fp32_add_sub_top i_dut (.*);

    fp32_add_sub_checker i_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side stalls in bursts until the final calm stretch.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 16);
                m_ready <= 0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hff;
            1: v[30:23] = 8'h00;
            2: v[30:0] = 31'd0;
            3: v[30:23] = 8'($urandom_range(250, 254));
            4: v[30:23] = 8'($urandom_range(0, 3));
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    task automatic send(logic kind, logic [31:0] a, logic [31:0] b);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            s_valid <= 0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] b;
        logic [31:0] a;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        send(0, 32'h3f800000, 32'h3f800000);
        send(1, 32'h3f800000, 32'h3f800000);
        send(0, 32'h7fc00001, 32'h3f800000);
        send(1, 32'h3f800000, 32'hff800001);
        send(0, 32'h7f800000, 32'hff800000);
        send(1, 32'h7f800000, 32'h7f800000);
        send(0, 32'hff800000, 32'hff800000);
        send(1, 32'h40000000, 32'hff800000);
        send(0, 32'h7f800000, 32'h12345678);
        send(0, 32'h00000000, 32'h80000000);
        send(1, 32'h80000000, 32'h80000000);
        send(0, 32'h00000001, 32'h00000000);
        send(0, 32'h4b800000, 32'h33800000);
        send(0, 32'h4b800000, 32'h34000000);
        send(0, 32'h3fffffff, 32'h33ffffff);
        send(0, 32'h7f7fffff, 32'h7f7fffff);
        send(1, 32'h00800000, 32'h00800001);
        send(1, 32'h00000001, 32'h00000002);
        send(0, 32'hffffffff, 32'h00000000);
        send(1, 32'hbf800000, 32'h3f800000);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 150) calm = 1;
            a = pick_operand();
            b = ($urandom_range(0, 3) == 0) ? (a ^ ($urandom() & 32'h8000000f))
                                            : pick_operand();
            send(1'($urandom_range(0, 1)), a, b);
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
